/* src/ffa_pkg.sv */
package ffa_pkg;

  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned DIVIDEND_W = 17;
  localparam int unsigned OUT_IDX_W  = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NOFIT = 2'd1,
    STATUS_ZERO  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_DONE,
    ST_A_DIV,
    ST_A_ISSUE,
    ST_A_CHK,
    ST_A_FIT,
    ST_A_FIT2,
    ST_A_WREST,
    ST_A_WCUR,
    ST_A_LINK,
    ST_F_ISSUE,
    ST_F_ADV,
    ST_F_RDB,
    ST_F_RDC,
    ST_F_M1,
    ST_F_M1A,
    ST_F_M2,
    ST_F_M2A
  } state_e;

  typedef struct packed {
    logic size_we;
    logic link_we;
  } mem_we_t;

endpackage

/* src/ffa_alu.sv */
module ffa_alu import ffa_pkg::*; (
  input  logic [SIZE_W-1:0] a_i,
  input  logic [SIZE_W-1:0] b_i,
  input  logic [SIZE_W-1:0] c_i,
  input  logic              sub_i,
  output logic [SIZE_W-1:0] res_o,
  output logic              lt_o,
  output logic              eq_o
);

  // wraps at 32 bits like the size arithmetic it serves
  assign res_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign lt_o  = (res_o < c_i);
  assign eq_o  = (res_o == c_i);

endmodule

/* src/ffa_div.sv */
module ffa_div #(
  parameter int unsigned DIVISOR = 8,
  parameter int unsigned NW      = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned DW = $clog2(DIVISOR);
  localparam int unsigned SH = NW + DW;
  localparam int unsigned MW = NW + 2;
  localparam int unsigned PW = NW + MW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic [PW-1:0] prod;
  logic          done_q;
  logic [NW-1:0] quo_q;

  // x / DIVISOR == (x * ceil(2^SH / DIVISOR)) >> SH for every NW-bit x
  assign prod = {{MW{1'b0}}, dividend_i} * {{NW{1'b0}}, RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= NW'(prod[PW-1:SH]);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/ffa_mem.sv */
module ffa_mem import ffa_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned LW    = 11
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [SIZE_W-1:0] rd_size_o,
  output logic [LW-1:0]     rd_link_o,
  input  mem_we_t           we_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [SIZE_W-1:0] wr_size_i,
  input  logic [LW-1:0]     wr_link_i
);

  logic [SIZE_W-1:0] size_mem [DEPTH];
  logic [LW-1:0]     link_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i.size_we) begin
      size_mem[wr_addr_i] <= wr_size_i;
    end
    if (we_i.link_we) begin
      link_mem[wr_addr_i] <= wr_link_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_size_o <= size_mem[rd_addr_i];
      rd_link_o <= link_mem[rd_addr_i];
    end
  end

endmodule

/* src/first_fit_heap_allocator.sv */
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+-------------------------------------
// request  | in_valid_i  | in_stall_o  | op_i, req_bytes_i, free_index_i
// result   | out_valid_o | out_stall_i | status_o, block_index_o
//
// One request at a time. Allocate: a registered reciprocal multiply gives the block count,
// then each free-list chunk visited takes an issue and a check state (registered read of
// the list memory), then the chunk is split and relinked. Free: walks the chunks ahead of
// the freed block, then merges with its neighbours and relinks. Each walk stops after
// NUM_BLOCKS + 1 chunks. After reset the INIT state writes the initial chunk header.
// A stalled result blocks completion of the next request only.
module first_fit_heap_allocator import ffa_pkg::*; #(
  parameter int unsigned NUM_BLOCKS   = 1024,
  parameter int unsigned BLOCK_BYTES  = 8,
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [15:0]          req_bytes_i,
  input  logic [OUT_IDX_W-1:0] free_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [OUT_IDX_W-1:0] block_index_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned IW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 2);
  localparam int unsigned SW = SIZE_W;
  localparam logic [IW-1:0] NIL     = IW'(NUM_BLOCKS);
  localparam logic [SW-1:0] NIL_W   = SW'(NUM_BLOCKS);
  localparam logic [CW-1:0] LIMIT   = CW'(NUM_BLOCKS + 1);
  localparam logic [DIVIDEND_W-1:0] ROUND_ADD =
    DIVIDEND_W'(BLOCK_BYTES + HEADER_BYTES - 1);

  state_e state_q, state_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [OUT_IDX_W-1:0]  out_index_q, out_index_d;
  status_e               pend_status_q, pend_status_d;
  logic [OUT_IDX_W-1:0]  pend_index_q, pend_index_d;

  logic [IW-1:0]         head_q, head_d;
  logic [IW-1:0]         cur_q, cur_d;
  logic [IW-1:0]         prev_q, prev_d;
  logic [IW-1:0]         rest_q, rest_d;
  logic [IW-1:0]         tgt_q, tgt_d;
  logic [IW-1:0]         link_c_q, link_c_d;
  logic [CW-1:0]         steps_q, steps_d;
  logic [DIVIDEND_W-1:0] need_q, need_d;
  logic [SW-1:0]         size_c_q, size_c_d;
  logic [SW-1:0]         size_p_q, size_p_d;
  logic [SW-1:0]         size_b_q, size_b_d;
  logic [OUT_IDX_W-1:0]  blk_q, blk_d;

  logic [SW-1:0] cur_w, prev_w, blk_w, need_w;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [SW-1:0]         rd_size;
  logic [IW-1:0]         rd_link;
  mem_we_t               we;
  logic [AW-1:0]         wr_addr;
  logic [SW-1:0]         wr_size;
  logic [IW-1:0]         wr_link;

  logic [SW-1:0]         alu_a, alu_b, alu_c, alu_res;
  logic                  alu_sub, alu_lt, alu_eq;

  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] div_quo;

  assign cur_w  = SW'(cur_q);
  assign prev_w = SW'(prev_q);
  assign blk_w  = SW'(blk_q);
  assign need_w = SW'(need_q);

  ffa_mem #(
    .DEPTH (NUM_BLOCKS),
    .AW    (AW),
    .LW    (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_size_o (rd_size),
    .rd_link_o (rd_link),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_size_i (wr_size),
    .wr_link_i (wr_link)
  );

  ffa_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .lt_o  (alu_lt),
    .eq_o  (alu_eq)
  );

  ffa_div #(
    .DIVISOR (BLOCK_BYTES),
    .NW      (DIVIDEND_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIVIDEND_W'(req_bytes_i) + ROUND_ADD),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_index_d   = out_index_q;
    pend_status_d = pend_status_q;
    pend_index_d  = pend_index_q;
    head_d        = head_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    rest_d        = rest_q;
    tgt_d         = tgt_q;
    link_c_d      = link_c_q;
    steps_d       = steps_q;
    need_d        = need_q;
    size_c_d      = size_c_q;
    size_p_d      = size_p_q;
    size_b_d      = size_b_q;
    blk_d         = blk_q;
    rd_en         = 1'b0;
    rd_addr       = cur_q[AW-1:0];
    we            = '0;
    wr_addr       = cur_q[AW-1:0];
    wr_size       = '0;
    wr_link       = '0;
    alu_a         = '0;
    alu_b         = '0;
    alu_c         = '0;
    alu_sub       = 1'b0;
    div_start     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        we      = '{size_we: 1'b1, link_we: 1'b1};
        wr_addr = '0;
        wr_size = NIL_W;
        wr_link = NIL;
        state_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          cur_d        = head_q;
          prev_d       = NIL;
          steps_d      = '0;
          blk_d        = free_index_i;
          pend_index_d = '0;
          if (op_i == OP_ALLOC) begin
            if (req_bytes_i == '0) begin
              pend_status_d = STATUS_ZERO;
              state_d       = ST_DONE;
            end else begin
              div_start = 1'b1;
              state_d   = ST_A_DIV;
            end
          end else begin
            if (SW'(free_index_i) >= NIL_W) begin
              pend_status_d = STATUS_RANGE;
              state_d       = ST_DONE;
            end else begin
              state_d = ST_F_ISSUE;
            end
          end
        end
      end

      ST_A_DIV: begin
        if (div_done) begin
          need_d  = div_quo;
          state_d = ST_A_ISSUE;
        end
      end

      ST_A_ISSUE: begin
        if (cur_q >= NIL || steps_q >= LIMIT) begin
          pend_status_d = STATUS_NOFIT;
          state_d       = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_A_CHK;
        end
      end

      ST_A_CHK: begin
        alu_a = rd_size;
        alu_c = need_w;
        if (alu_lt) begin
          prev_d  = cur_q;
          cur_d   = rd_link;
          steps_d = steps_q + 1'b1;
          state_d = ST_A_ISSUE;
        end else begin
          size_c_d = rd_size;
          link_c_d = rd_link;
          state_d  = ST_A_FIT;
        end
      end

      ST_A_FIT: begin
        alu_a = need_w;
        alu_c = size_c_q;
        if (alu_lt) begin
          state_d = ST_A_FIT2;
        end else begin
          tgt_d   = link_c_q;
          state_d = ST_A_LINK;
        end
      end

      ST_A_FIT2: begin
        // remainder must start inside the heap
        alu_a = cur_w;
        alu_b = need_w;
        alu_c = NIL_W;
        if (alu_lt) begin
          rest_d  = alu_res[IW-1:0];
          state_d = ST_A_WREST;
        end else begin
          tgt_d   = link_c_q;
          state_d = ST_A_LINK;
        end
      end

      ST_A_WREST: begin
        alu_a   = size_c_q;
        alu_b   = need_w;
        alu_sub = 1'b1;
        we      = '{size_we: 1'b1, link_we: 1'b1};
        wr_addr = rest_q[AW-1:0];
        wr_size = alu_res;
        wr_link = link_c_q;
        state_d = ST_A_WCUR;
      end

      ST_A_WCUR: begin
        we      = '{size_we: 1'b1, link_we: 1'b1};
        wr_addr = cur_q[AW-1:0];
        wr_size = need_w;
        wr_link = rest_q;
        tgt_d   = rest_q;
        state_d = ST_A_LINK;
      end

      ST_A_LINK: begin
        if (prev_q < NIL) begin
          we      = '{size_we: 1'b0, link_we: 1'b1};
          wr_addr = prev_q[AW-1:0];
          wr_link = tgt_q;
        end else begin
          head_d = tgt_q;
        end
        pend_status_d = STATUS_OK;
        pend_index_d  = cur_w[OUT_IDX_W-1:0];
        state_d       = ST_DONE;
      end

      ST_F_ISSUE: begin
        alu_a = cur_w;
        alu_c = blk_w;
        if (cur_q < NIL && alu_lt && steps_q < LIMIT) begin
          rd_en   = 1'b1;
          state_d = ST_F_ADV;
        end else begin
          state_d = ST_F_RDB;
        end
      end

      ST_F_ADV: begin
        prev_d   = cur_q;
        size_p_d = rd_size;
        cur_d    = rd_link;
        steps_d  = steps_q + 1'b1;
        state_d  = ST_F_ISSUE;
      end

      ST_F_RDB: begin
        rd_en   = 1'b1;
        rd_addr = blk_w[AW-1:0];
        state_d = ST_F_RDC;
      end

      ST_F_RDC: begin
        size_b_d = rd_size;
        rd_en    = (cur_q < NIL);
        state_d  = ST_F_M1;
      end

      ST_F_M1: begin
        // merge with the chunk that directly follows
        alu_a = blk_w;
        alu_b = size_b_q;
        alu_c = cur_w;
        if (cur_q < NIL && alu_eq) begin
          size_c_d = rd_size;
          link_c_d = rd_link;
          state_d  = ST_F_M1A;
        end else begin
          we      = '{size_we: 1'b0, link_we: 1'b1};
          wr_addr = blk_w[AW-1:0];
          wr_link = cur_q;
          tgt_d   = cur_q;
          state_d = ST_F_M2;
        end
      end

      ST_F_M1A: begin
        alu_a    = size_b_q;
        alu_b    = size_c_q;
        we       = '{size_we: 1'b1, link_we: 1'b1};
        wr_addr  = blk_w[AW-1:0];
        wr_size  = alu_res;
        wr_link  = link_c_q;
        size_b_d = alu_res;
        tgt_d    = link_c_q;
        state_d  = ST_F_M2;
      end

      ST_F_M2: begin
        // merge into the chunk that directly precedes
        alu_a         = prev_w;
        alu_b         = size_p_q;
        alu_c         = blk_w;
        pend_status_d = STATUS_OK;
        if (prev_q < NIL && alu_eq) begin
          state_d = ST_F_M2A;
        end else begin
          if (prev_q < NIL) begin
            we      = '{size_we: 1'b0, link_we: 1'b1};
            wr_addr = prev_q[AW-1:0];
            wr_link = blk_w[IW-1:0];
          end else begin
            head_d = blk_w[IW-1:0];
          end
          state_d = ST_DONE;
        end
      end

      ST_F_M2A: begin
        alu_a   = size_p_q;
        alu_b   = size_b_q;
        we      = '{size_we: 1'b1, link_we: 1'b1};
        wr_addr = prev_q[AW-1:0];
        wr_size = alu_res;
        wr_link = tgt_q;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_index_d  = pend_index_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      head_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q  <= out_status_d;
    out_index_q   <= out_index_d;
    pend_status_q <= pend_status_d;
    pend_index_q  <= pend_index_d;
    cur_q         <= cur_d;
    prev_q        <= prev_d;
    rest_q        <= rest_d;
    tgt_q         <= tgt_d;
    link_c_q      <= link_c_d;
    steps_q       <= steps_d;
    need_q        <= need_d;
    size_c_q      <= size_c_d;
    size_p_q      <= size_p_d;
    size_b_q      <= size_b_d;
    blk_q         <= blk_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign block_index_o = out_index_q;

endmodule

/* src/ffa_checker.sv */
module ffa_checker import ffa_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 op_i,
  input logic [15:0]          req_bytes_i,
  input logic [OUT_IDX_W-1:0] free_index_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           status_o,
  input logic [OUT_IDX_W-1:0] block_index_o
);

  // one request in flight: an accepted request closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still running");

  a_in_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(op_i) &&
      $stable(req_bytes_i) && $stable(free_index_i))
    else $error("stalled request changed");

  a_index_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> block_index_o == '0)
    else $error("nonzero block index on failed request");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(block_index_o))
    else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .op_i          (op_i),
  .req_bytes_i   (req_bytes_i),
  .free_index_i  (free_index_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .block_index_o (block_index_o)
);
